// ===== hdl/imm_pkg.sv =====
// Package with shared constants and types for the interleaved modular multiplier.
`default_nettype none

package imm_pkg;

  localparam int FIELD_W   = 64;
  localparam int WIDTH_DEF = 64;

  localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RED  = 5'b00010,
    S_DBL  = 5'b00100,
    S_ADD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic red_step;
    logic mul_dbl;
    logic mul_add;
    logic out_load;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/imm_datapath.sv =====
// Datapath: modulus register, operand reduction, shift-add accumulator and result register.
`default_nettype none

module imm_datapath #(
  parameter int WIDTH = imm_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [imm_pkg::FIELD_W-1:0] cfg_wdata,
  input  wire logic [imm_pkg::FIELD_W-1:0] in_a,
  input  wire logic [imm_pkg::FIELD_W-1:0] in_b,
  input  wire imm_pkg::cmd_t               cmd,
  output logic      [imm_pkg::FIELD_W-1:0] out_product,
  output logic                             out_err
);

  logic [imm_pkg::FIELD_W-1:0] mod_r;
  logic [WIDTH-1:0]            op_a_r, op_b_r;
  logic [WIDTH-1:0]            rem_a_r, rem_b_r;
  logic [WIDTH-1:0]            acc_r;
  logic [imm_pkg::FIELD_W-1:0] prod_r;
  logic                        err_r;

  logic [WIDTH-1:0]            m;
  logic                        m_zero;
  logic [WIDTH:0]              add_sum;
  logic [WIDTH-1:0]            red_a_nxt, red_b_nxt, dbl_nxt, add_nxt;

  // Subtracts the modulus once from a value below twice the modulus.
  function automatic logic [WIDTH-1:0] reduce_once(input logic [WIDTH:0] val,
                                                   input logic [WIDTH-1:0] md);
    logic [WIDTH:0] diff;
    diff = val - {1'b0, md};
    if (val >= {1'b0, md}) begin
      return diff[WIDTH-1:0];
    end
    return val[WIDTH-1:0];
  endfunction

  assign m      = mod_r[WIDTH-1:0];
  assign m_zero = (m == '0);

  assign red_a_nxt = reduce_once({rem_a_r, op_a_r[WIDTH-1]}, m);
  assign red_b_nxt = reduce_once({rem_b_r, op_b_r[WIDTH-1]}, m);
  assign dbl_nxt   = reduce_once({acc_r, 1'b0}, m);
  assign add_sum   = {1'b0, acc_r} + {1'b0, (rem_a_r[WIDTH-1] ? rem_b_r : '0)};
  assign add_nxt   = reduce_once(add_sum, m);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= imm_pkg::MODULUS_RESET;
    end else if (cfg_we) begin
      mod_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_a_r  <= in_a[WIDTH-1:0];
      op_b_r  <= in_b[WIDTH-1:0];
      rem_a_r <= '0;
      rem_b_r <= '0;
      acc_r   <= '0;
    end else if (cmd.red_step) begin
      op_a_r  <= {op_a_r[WIDTH-2:0], 1'b0};
      op_b_r  <= {op_b_r[WIDTH-2:0], 1'b0};
      rem_a_r <= red_a_nxt;
      rem_b_r <= red_b_nxt;
    end else if (cmd.mul_dbl) begin
      acc_r <= dbl_nxt;
    end else if (cmd.mul_add) begin
      acc_r   <= add_nxt;
      rem_a_r <= {rem_a_r[WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      prod_r <= m_zero ? '0 : imm_pkg::FIELD_W'(acc_r);
      err_r  <= m_zero;
    end
  end

  assign out_product = prod_r;
  assign out_err     = err_r;

endmodule

`default_nettype wire

// ===== hdl/imm_controller.sv =====
// Controller: sequences reduction and multiplication steps and owns the handshakes.
`default_nettype none

module imm_controller #(
  parameter int WIDTH = imm_pkg::WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output imm_pkg::cmd_t      cmd
);

  localparam int CW = $clog2(WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

  imm_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            last;

  assign last = (cnt_r == CNT_LAST);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      imm_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = imm_pkg::S_RED;
        end
      end
      imm_pkg::S_RED: begin
        cmd.red_step = 1'b1;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = imm_pkg::S_DBL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      imm_pkg::S_DBL: begin
        cmd.mul_dbl = 1'b1;
        state_nxt   = imm_pkg::S_ADD;
      end
      imm_pkg::S_ADD: begin
        cmd.mul_add = 1'b1;
        if (last) begin
          cnt_nxt   = '0;
          state_nxt = imm_pkg::S_FIN;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = imm_pkg::S_DBL;
        end
      end
      imm_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = imm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = imm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imm_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == imm_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== hdl/interleaved_modular_multiplier_top.sv =====
// Top level of the interleaved modular multiplier.
//
//   Channel | Signals                                           | Direction
//   --------+---------------------------------------------------+----------
//   cfg     | cfg_we, cfg_wdata                                 | in
//   in      | in_valid, in_ready, in_multiplicand_a/b           | in
//   out     | out_valid, out_ready, out_product_mod,            | out
//           | out_zero_modulus_error                            |
//
// An item passes through restoring reduction of both operands side by side (S_RED), then
// a doubling step and a conditional-add step for each bit of the reduced a (S_DBL, S_ADD),
// each with one subtraction of the modulus, then a step that loads the result (S_FIN).
// The next item is accepted once the controller is back in S_IDLE.
// One item is worked on at a time.
// Reset is synchronous and sets the modulus to one. A stalled result waits in the output
// register while the next item is accepted; that item then holds in its last step until
// the register is free.
`default_nettype none

module interleaved_modular_multiplier_top #(
  parameter int WIDTH = imm_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [imm_pkg::FIELD_W-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [imm_pkg::FIELD_W-1:0] in_multiplicand_a,
  input  wire logic [imm_pkg::FIELD_W-1:0] in_multiplicand_b,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [imm_pkg::FIELD_W-1:0] out_product_mod,
  output logic                             out_zero_modulus_error
);

  imm_pkg::cmd_t cmd;

  imm_controller #(
    .WIDTH(WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  imm_datapath #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_a       (in_multiplicand_a),
    .in_b       (in_multiplicand_b),
    .cmd        (cmd),
    .out_product(out_product_mod),
    .out_err    (out_zero_modulus_error)
  );

endmodule

`default_nettype wire

// ===== bench/imm_product_checker.sv =====
// Checker for the interleaved modular multiplier: predicts every product and compares results.
`timescale 1ns / 1ps

module imm_product_checker #(
  parameter int WIDTH = imm_pkg::WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [imm_pkg::FIELD_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [imm_pkg::FIELD_W-1:0] in_multiplicand_a,
  input  logic [imm_pkg::FIELD_W-1:0] in_multiplicand_b,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [imm_pkg::FIELD_W-1:0] out_product_mod,
  input  logic                        out_zero_modulus_error,
  output int unsigned                 mismatches,
  output int unsigned                 pending,
  output int unsigned                 products_checked,
  output int unsigned                 zero_modulus_seen
);

  import imm_pkg::*;

  localparam logic [FIELD_W-1:0] OPERAND_MASK = {FIELD_W{1'b1}} >> (FIELD_W - WIDTH);

  typedef struct packed {
    logic [FIELD_W-1:0] product;
    logic               zero_modulus;
  } product_t;

  logic [FIELD_W-1:0] modulus_q;
  product_t           product_q[$];
  int unsigned        bad_count;
  int unsigned        seen_count;
  int unsigned        zero_count;

  function automatic product_t mod_product(input logic [FIELD_W-1:0] a,
                                           input logic [FIELD_W-1:0] b,
                                           input logic [FIELD_W-1:0] m);
    logic [2*FIELD_W-1:0] a_red;
    logic [2*FIELD_W-1:0] b_red;
    logic [2*FIELD_W-1:0] m_wide;
    product_t             p;
    m_wide = m & OPERAND_MASK;
    a_red = a & OPERAND_MASK;
    b_red = b & OPERAND_MASK;
    p.zero_modulus = (m_wide == 0);
    p.product = '0;
    if (!p.zero_modulus) begin
      a_red = a_red % m_wide;
      b_red = b_red % m_wide;
      p.product = FIELD_W'((a_red * b_red) % m_wide);
    end
    return p;
  endfunction

  always @(posedge clk) begin
    product_t got;
    product_t want;
    if (!rst_n) begin
      modulus_q = MODULUS_RESET;
      product_q.delete();
      bad_count = 0;
      seen_count = 0;
      zero_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        product_q.push_back(mod_product(in_multiplicand_a, in_multiplicand_b, modulus_q));
      end
      if (cfg_we) begin
        modulus_q = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        got.product = out_product_mod;
        got.zero_modulus = out_zero_modulus_error;
        seen_count++;
        if (got.zero_modulus) begin
          zero_count++;
        end
        if (product_q.size() == 0) begin
          bad_count++;
          if (bad_count <= 10) begin
            $display("%0t: result with no item outstanding: product %h, zero modulus %b",
                     $time, got.product, got.zero_modulus);
          end
        end else begin
          want = product_q.pop_front();
          if (got.product !== want.product || got.zero_modulus !== want.zero_modulus) begin
            bad_count++;
            if (bad_count <= 10) begin
              $display("%0t: expected product %h, zero modulus %b; got product %h, zero modulus %b",
                       $time, want.product, want.zero_modulus, got.product, got.zero_modulus);
            end
          end
        end
      end
    end
    mismatches <= bad_count;
    pending <= product_q.size();
    products_checked <= seen_count;
    zero_modulus_seen <= zero_count;
  end

endmodule

// ===== bench/tb_top.sv =====
// Testbench top for the interleaved modular multiplier: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  import imm_pkg::*;

  localparam int                 WIDTH       = WIDTH_DEF;
  localparam int                 LATENCY     = 3 * WIDTH + 2;
  localparam int                 HOLD_CYCLES = 800;
  localparam int                 IDLE_LIMIT  = 8000;
  localparam int                 PHASES      = 12;
  localparam int                 PHASE_ITEMS = 56;
  localparam logic [FIELD_W-1:0] ALL_ONES    = '1;
  localparam logic [FIELD_W-1:0] TOP_BIT     = {1'b1, {(FIELD_W-1){1'b0}}};

  typedef enum int {MK_FULL, MK_ANY_WIDTH, MK_SMALL, MK_POW2, MK_ONES, MK_ZERO} mod_kind_t;
  typedef enum int {RX_OPEN, RX_PATCHY, RX_SPARSE} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [FIELD_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FIELD_W-1:0] in_multiplicand_a = '0;
  logic [FIELD_W-1:0] in_multiplicand_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [FIELD_W-1:0] out_product_mod;
  logic               out_zero_modulus_error;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned products_checked;
  int unsigned zero_modulus_seen;
  int unsigned pairs_sent = 0;
  int unsigned moduli_written = 0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;

  interleaved_modular_multiplier_top #(
    .WIDTH(WIDTH)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_multiplicand_a     (in_multiplicand_a),
    .in_multiplicand_b     (in_multiplicand_b),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_product_mod       (out_product_mod),
    .out_zero_modulus_error(out_zero_modulus_error)
  );

  imm_product_checker #(
    .WIDTH(WIDTH)
  ) i_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_multiplicand_a     (in_multiplicand_a),
    .in_multiplicand_b     (in_multiplicand_b),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_product_mod       (out_product_mod),
    .out_zero_modulus_error(out_zero_modulus_error),
    .mismatches            (mismatches),
    .pending               (pending),
    .products_checked      (products_checked),
    .zero_modulus_seen     (zero_modulus_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [FIELD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [FIELD_W-1:0] pick_modulus(input mod_kind_t kind);
    case (kind)
      MK_FULL:      return rand64() | TOP_BIT;
      MK_ANY_WIDTH: return rand64() >> $urandom_range(0, FIELD_W - 1);
      MK_SMALL:     return FIELD_W'($urandom_range(2, 300));
      MK_POW2:      return FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
      MK_ONES:      return ALL_ONES >> $urandom_range(0, FIELD_W - 1);
      default:      return '0;
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] pick_operand(input logic [FIELD_W-1:0] m);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return m * FIELD_W'($urandom_range(1, 5));
      3:       return m - FIELD_W'(1);
      4:       return m + FIELD_W'($urandom_range(0, 3));
      5:       return (m == '0) ? rand64() : rand64() % m;
      6:       return FIELD_W'($urandom_range(1, 16));
      default: return rand64();
    endcase
  endfunction

  task automatic push_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    in_valid <= 1'b1;
    in_multiplicand_a <= a;
    in_multiplicand_b <= b;
    do @(posedge clk); while (!in_ready);
    pairs_sent++;
  endtask

  task automatic write_modulus(input logic [FIELD_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    moduli_written++;
  endtask

  task automatic run_phase(input logic [FIELD_W-1:0] m, input int n_items, input bit squeeze);
    int sent;
    int burst;
    int gap;
    sent = 0;
    write_modulus(m);
    if (squeeze) begin
      squeeze_req = 1'b1;
    end
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        push_pair(pick_operand(m), pick_operand(m));
        sent++;
      end
      case ($urandom_range(0, 3))
        0:       gap = 0;
        3:       gap = $urandom_range(1, LATENCY + 20);
        default: gap = $urandom_range(1, 20);
      endcase
      if (sent < n_items && gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // The receiver holds off once for a long stretch so that the block fills and stalls its input.
  initial begin
    int       mode_left;
    rx_mode_t mode;
    mode_left = 0;
    mode = RX_OPEN;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_PATCHY: out_ready <= ($urandom_range(0, 1) == 1);
        default:   out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Timeout: no handshake for %0d cycles, %0d results outstanding.",
             IDLE_LIMIT, pending);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [FIELD_W-1:0] m;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_modulus(MODULUS_RESET);
    push_pair(FIELD_W'(5), FIELD_W'(7));
    push_pair(ALL_ONES, ALL_ONES);

    write_modulus(ALL_ONES);
    push_pair(ALL_ONES, ALL_ONES);
    push_pair(ALL_ONES - FIELD_W'(1), ALL_ONES - FIELD_W'(1));
    push_pair(TOP_BIT, FIELD_W'(2));
    push_pair('0, FIELD_W'(5));
    push_pair(FIELD_W'(5), '0);
    push_pair(FIELD_W'(1), ALL_ONES - FIELD_W'(1));

    write_modulus('0);
    push_pair(FIELD_W'(3), FIELD_W'(4));
    push_pair('0, '0);
    push_pair(ALL_ONES, ALL_ONES);

    write_modulus(FIELD_W'(7));
    push_pair(FIELD_W'(7), FIELD_W'(3));
    push_pair(FIELD_W'(8), FIELD_W'(9));
    push_pair(ALL_ONES, ALL_ONES);
    push_pair(FIELD_W'(14), ALL_ONES);

    write_modulus(ALL_ONES - FIELD_W'(58));
    push_pair(ALL_ONES - FIELD_W'(59), ALL_ONES - FIELD_W'(59));
    push_pair(ALL_ONES, TOP_BIT);
    push_pair(ALL_ONES - FIELD_W'(59), {(FIELD_W/2){2'b01}});

    for (int ph = 0; ph < PHASES; ph++) begin
      m = pick_modulus(mod_kind_t'(ph % 6));
      run_phase(m, (m == '0) ? 15 : PHASE_ITEMS, ph == 1);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 20) @(posedge clk);

    $display("Sent %0d operand pairs under %0d modulus writes; %0d results checked,",
             pairs_sent, moduli_written, products_checked);
    $display("%0d of them with a zero modulus, %0d mismatches.",
             zero_modulus_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
